// ----- sv/s2c_pkg.sv -----
package s2c_pkg;

  // round(2^31/pi): Q3.12 radians to 32-bit binary angle, with a 12-bit shift
  localparam logic signed [31:0] RAD_TO_BAM  = 32'sd683565276;
  // cordic gain compensation in Q2.30
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  // smallest elevation magnitude that gets folded
  localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
  localparam logic [31:0]        HALF_TURN   = 32'h8000_0000;

  typedef logic signed [31:0] cval_t;

  // rotator state for both angles
  typedef struct packed {
    cval_t x_a;
    cval_t y_a;
    cval_t z_a;
    cval_t x_b;
    cval_t y_b;
    cval_t z_b;
    logic  neg_a;
    logic  neg_b;
  } rot_t;

  // atan(2^-i) in binary angle units
  function automatic cval_t atan_bam(input logic [4:0] idx);
    case (idx)
      5'd0:    return 32'sh2000_0000;
      5'd1:    return 32'sh12E4_051E;
      5'd2:    return 32'sh09FB_385B;
      5'd3:    return 32'sh0511_11D4;
      5'd4:    return 32'sh028B_0D43;
      5'd5:    return 32'sh0145_D7E1;
      5'd6:    return 32'sh00A2_F61E;
      5'd7:    return 32'sh0051_7C55;
      5'd8:    return 32'sh0028_BE53;
      5'd9:    return 32'sh0014_5F2F;
      5'd10:   return 32'sh000A_2F98;
      5'd11:   return 32'sh0005_17CC;
      5'd12:   return 32'sh0002_8BE6;
      5'd13:   return 32'sh0001_45F3;
      5'd14:   return 32'sh0000_A2FA;
      5'd15:   return 32'sh0000_517D;
      5'd16:   return 32'sh0000_28BE;
      5'd17:   return 32'sh0000_145F;
      5'd18:   return 32'sh0000_0A30;
      5'd19:   return 32'sh0000_0518;
      5'd20:   return 32'sh0000_028C;
      5'd21:   return 32'sh0000_0146;
      5'd22:   return 32'sh0000_00A3;
      5'd23:   return 32'sh0000_0051;
      default: return 32'sh0000_0000;
    endcase
  endfunction

endpackage

// ----- sv/s2c_bam.sv -----
module s2c_bam
  import s2c_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] azimuth,
  input  logic signed [15:0] elevation,
  output logic               out_valid,
  input  logic               out_ready,
  output rot_t               out_data
);

  logic               v1_r;
  logic signed [47:0] pa_r, pb_r;
  logic               fold_r;
  logic signed [47:0] pa_nxt, pb_nxt;
  logic               fold_nxt;
  logic               ready1, ready2;

  logic               v2_r;
  rot_t               rot_r;
  rot_t               rot_nxt;
  logic signed [47:0] ra, rb;
  logic [31:0]        ab, bb;
  logic [32:0]        qa, qb;

  // quadrant reduction: {negate, z in [-pi/2, pi/2)}
  function automatic logic [32:0] reduce(input logic [31:0] th);
    logic        neg;
    logic [31:0] t;
    neg = (th[31:30] == 2'b01) || (th[31:30] == 2'b10);
    t   = neg ? th + HALF_TURN : th;
    return {neg, t};
  endfunction

  assign ready2   = !v2_r || out_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  assign pa_nxt   = 48'(azimuth) * 48'(RAD_TO_BAM);
  assign pb_nxt   = 48'(elevation) * 48'(RAD_TO_BAM);
  assign fold_nxt = (elevation >= HALF_PI_Q12) || (elevation <= -HALF_PI_Q12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      fold_r <= fold_nxt;
    end
  end

  always_comb begin
    ra = pa_r + 48'sd2048;
    rb = pb_r + 48'sd2048;
    ab = ra[43:12];
    bb = rb[43:12];
    if (fold_r) begin
      bb = HALF_TURN - bb;
      ab = ab - HALF_TURN;
    end
    qa = reduce(ab);
    qb = reduce(bb);
    rot_nxt.x_a   = CORDIC_GAIN;
    rot_nxt.y_a   = '0;
    rot_nxt.z_a   = qa[31:0];
    rot_nxt.neg_a = qa[32];
    rot_nxt.x_b   = CORDIC_GAIN;
    rot_nxt.y_b   = '0;
    rot_nxt.z_b   = qb[31:0];
    rot_nxt.neg_b = qb[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1_r) begin
      rot_r <= rot_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = rot_r;

endmodule

// ----- sv/s2c_cordic_stage.sv -----
module s2c_cordic_stage
  import s2c_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rot_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rot_t out_data
);

  localparam cval_t ATAN = atan_bam(5'(IDX));

  logic  v_r;
  rot_t  d_r;
  rot_t  d_nxt;
  logic  rdy;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    d_nxt = in_data;
    if (!in_data.z_a[31]) begin
      d_nxt.x_a = in_data.x_a - (in_data.y_a >>> IDX);
      d_nxt.y_a = in_data.y_a + (in_data.x_a >>> IDX);
      d_nxt.z_a = in_data.z_a - ATAN;
    end else begin
      d_nxt.x_a = in_data.x_a + (in_data.y_a >>> IDX);
      d_nxt.y_a = in_data.y_a - (in_data.x_a >>> IDX);
      d_nxt.z_a = in_data.z_a + ATAN;
    end
    if (!in_data.z_b[31]) begin
      d_nxt.x_b = in_data.x_b - (in_data.y_b >>> IDX);
      d_nxt.y_b = in_data.y_b + (in_data.x_b >>> IDX);
      d_nxt.z_b = in_data.z_b - ATAN;
    end else begin
      d_nxt.x_b = in_data.x_b + (in_data.y_b >>> IDX);
      d_nxt.y_b = in_data.y_b - (in_data.x_b >>> IDX);
      d_nxt.z_b = in_data.z_b + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ----- sv/s2c_product.sv -----
module s2c_product
  import s2c_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14,
  parameter int OUT_W         = OUT_FRAC_BITS + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rot_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] dir_x,
  output logic [OUT_W-1:0] dir_y,
  output logic [OUT_W-1:0] dir_z
);

  localparam int SH_P = 60 - OUT_FRAC_BITS;
  localparam int SH_Y = 30 - OUT_FRAC_BITS;
  localparam logic signed [63:0] RND_P = (64'sd1 <<< SH_P) >>> 1;
  localparam logic signed [63:0] RND_Y = (64'sd1 <<< SH_Y) >>> 1;
  localparam logic signed [63:0] LIM   = 64'sd1 <<< OUT_FRAC_BITS;

  logic               rdy1, rdy2, rdy3;
  logic               v1_r, v2_r, v3_r;
  cval_t              sa_r, ca_r, sb_r, cb_r;
  cval_t              sb2_r;
  logic signed [63:0] px_r, pz_r;
  logic signed [63:0] px_nxt, pz_nxt;
  logic signed [63:0] rx, ry, rz;
  logic [OUT_W-1:0]   dx_r, dy_r, dz_r;

  function automatic logic [OUT_W-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (c > LIM) c = LIM;
    if (c < -LIM) c = -LIM;
    return c[OUT_W-1:0];
  endfunction

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // undo the half-turn taken off during quadrant reduction
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sa_r <= in_data.neg_a ? -in_data.y_a : in_data.y_a;
      ca_r <= in_data.neg_a ? -in_data.x_a : in_data.x_a;
      sb_r <= in_data.neg_b ? -in_data.y_b : in_data.y_b;
      cb_r <= in_data.neg_b ? -in_data.x_b : in_data.x_b;
    end
  end

  assign px_nxt = cb_r * sa_r;
  assign pz_nxt = cb_r * ca_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      px_r  <= px_nxt;
      pz_r  <= pz_nxt;
      sb2_r <= sb_r;
    end
  end

  // round half up, then clamp to +-1
  assign rx = (px_r + RND_P) >>> SH_P;
  assign rz = (pz_r + RND_P) >>> SH_P;
  assign ry = (64'(sb2_r) + RND_Y) >>> SH_Y;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      dx_r <= sat(rx);
      dy_r <= sat(ry);
      dz_r <= sat(rz);
    end
  end

  assign out_valid = v3_r;
  assign dir_x     = dx_r;
  assign dir_y     = dy_r;
  assign dir_z     = dz_r;

endmodule

// ----- sv/spherical_to_cartesian.sv -----
// Spherical to Cartesian direction unit. Each request carries an azimuth and an
// elevation in signed Q3.12 radians and yields the unit vector
// x = cos(el)*sin(az), y = sin(el), z = cos(el)*cos(az) in signed
// Q1.OUT_FRAC_BITS, clamped to +-1. Elevations beyond +-pi/2 are folded over
// the pole first. A new request can be taken every clock cycle unless the
// output stalls. The pipeline runs angle conversion, then quadrant reduction,
// then an unrolled CORDIC stage for each iteration, then sign fix, product and
// rounding. Backpressure on the output fills empty pipeline slots before
// in_tready drops.
module spherical_to_cartesian
  import s2c_pkg::*;
#(
  parameter  int CORDIC_STAGES = 16,
  parameter  int OUT_FRAC_BITS = 14,
  localparam int OUT_W         = OUT_FRAC_BITS + 2,
  localparam int OUT_DW        = ((3 * OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // azimuth[15:0], elevation[31:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // dir_x, dir_y, dir_z from bit 0, zero padded
);

  rot_t             chain_d   [CORDIC_STAGES+1];
  logic             chain_v   [CORDIC_STAGES+1];
  logic             chain_rdy [CORDIC_STAGES+1];
  logic [OUT_W-1:0] dir_x, dir_y, dir_z;

  s2c_bam u_bam (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .azimuth   (in_tdata[15:0]),
    .elevation (in_tdata[31:16]),
    .out_valid (chain_v[0]),
    .out_ready (chain_rdy[0]),
    .out_data  (chain_d[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    s2c_cordic_stage #(.IDX(g)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[g]),
      .in_ready  (chain_rdy[g]),
      .in_data   (chain_d[g]),
      .out_valid (chain_v[g+1]),
      .out_ready (chain_rdy[g+1]),
      .out_data  (chain_d[g+1])
    );
  end

  s2c_product #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .OUT_W         (OUT_W)
  ) u_product (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_v[CORDIC_STAGES]),
    .in_ready  (chain_rdy[CORDIC_STAGES]),
    .in_data   (chain_d[CORDIC_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z)
  );

  assign out_tdata = OUT_DW'({dir_z, dir_y, dir_x});

  // a ready sink must propagate all the way back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // input only stalls when a finished result is held at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(dir_x) <= $signed(OUT_W'(1) << OUT_FRAC_BITS)) &&
                   ($signed(dir_x) >= -$signed(OUT_W'(1) << OUT_FRAC_BITS)))
    else $error("dir_x out of range");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(dir_y) <= $signed(OUT_W'(1) << OUT_FRAC_BITS)) &&
                   ($signed(dir_y) >= -$signed(OUT_W'(1) << OUT_FRAC_BITS)))
    else $error("dir_y out of range");

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(dir_z) <= $signed(OUT_W'(1) << OUT_FRAC_BITS)) &&
                   ($signed(dir_z) >= -$signed(OUT_W'(1) << OUT_FRAC_BITS)))
    else $error("dir_z out of range");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

package direction_check_pkg;

  localparam int ROT_STAGES = 16;
  localparam int FRAC_BITS  = 14;
  localparam int DIR_W      = FRAC_BITS + 2;
  localparam int RES_W      = ((3 * DIR_W + 7) / 8) * 8;

  localparam longint Q12_TO_TURN = 64'sd683565276;
  localparam longint ROT_GAIN    = 64'sd652032874;
  localparam int     FOLD_Q12    = 6434;
  localparam int     ARCTAN_LEN  = 24;

  // atan(2^-i), one full turn = 2^32
  localparam longint ARCTAN_TURN [ARCTAN_LEN] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct {
    logic [DIR_W-1:0] x;
    logic [DIR_W-1:0] y;
    logic [DIR_W-1:0] z;
  } direction_t;

  class direction_board;
    direction_t pending_dirs[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function logic [31:0] angle_to_turn(logic signed [15:0] q);
      longint p;
      p = longint'(q) * Q12_TO_TURN + 64'sd2048;
      return p[43:12];
    endfunction

    // sine and cosine in Q2.30
    function void rotate_turn(logic [31:0] theta, output longint sin_v, output longint cos_v);
      logic        flip;
      logic [31:0] t;
      longint      px, py, pz, dx, dy;
      int          i;
      flip = (theta[31:30] == 2'b01) || (theta[31:30] == 2'b10);
      t = flip ? theta + 32'h8000_0000 : theta;
      pz = longint'($signed(t));
      px = ROT_GAIN;
      py = 0;
      for (i = 0; i < ROT_STAGES && i < ARCTAN_LEN; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        if (pz >= 0) begin
          px -= dx;
          py += dy;
          pz -= ARCTAN_TURN[i];
        end else begin
          px += dx;
          py -= dy;
          pz += ARCTAN_TURN[i];
        end
      end
      sin_v = flip ? -py : py;
      cos_v = flip ? -px : px;
    endfunction

    function logic [DIR_W-1:0] round_clamp(longint v, int shift);
      longint r, lim;
      lim = longint'(1) << FRAC_BITS;
      r = (v + (longint'(1) << (shift - 1))) >>> shift;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[DIR_W-1:0];
    endfunction

    function direction_t predict_direction(logic signed [15:0] az, logic signed [15:0] el);
      logic [31:0] az_turn, el_turn;
      longint      sa, ca, se, ce;
      direction_t  d;
      az_turn = angle_to_turn(az);
      el_turn = angle_to_turn(el);
      // fold over the pole
      if (el >= FOLD_Q12 || el <= -FOLD_Q12) begin
        el_turn = 32'h8000_0000 - el_turn;
        az_turn = az_turn - 32'h8000_0000;
      end
      rotate_turn(az_turn, sa, ca);
      rotate_turn(el_turn, se, ce);
      d.x = round_clamp(ce * sa, 60 - FRAC_BITS);
      d.y = round_clamp(se, 30 - FRAC_BITS);
      d.z = round_clamp(ce * ca, 60 - FRAC_BITS);
      return d;
    endfunction

    function void note_angles(logic [31:0] req);
      pending_dirs.push_back(predict_direction(req[15:0], req[31:16]));
    endfunction

    function void check_direction(logic [RES_W-1:0] res);
      direction_t exp_d, got;
      got.x = res[DIR_W-1:0];
      got.y = res[2*DIR_W-1:DIR_W];
      got.z = res[3*DIR_W-1:2*DIR_W];
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 $signed(got.x), $signed(got.y), $signed(got.z));
        errors++;
        return;
      end
      exp_d = pending_dirs.pop_front();
      if (got.x !== exp_d.x) begin
        $display("%0t: dir_x expected %0d got %0d", $time, $signed(exp_d.x), $signed(got.x));
        errors++;
      end
      if (got.y !== exp_d.y) begin
        $display("%0t: dir_y expected %0d got %0d", $time, $signed(exp_d.y), $signed(got.y));
        errors++;
      end
      if (got.z !== exp_d.z) begin
        $display("%0t: dir_z expected %0d got %0d", $time, $signed(exp_d.z), $signed(got.z));
        errors++;
      end
    endfunction
  endclass

endpackage

module testbench;
  import direction_check_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int DIRECTED_LEN = 20;
  localparam int PIPE_DEPTH   = ROT_STAGES + 5;
  localparam int STALL_LIMIT  = 1000;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [RES_W-1:0] out_tdata;

  int idle_mode = 0;

  direction_board board;

  // azimuth, elevation pairs: extremes, fold edges, multiples of pi
  logic signed [15:0] edge_az [DIRECTED_LEN] = '{
    16'sd0, 16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd12868,
    -16'sd12868, 16'sd6434, -16'sd6434, 16'sd25736, 16'sd1000,
    16'sd1000, -16'sd5000, 16'sd3000, 16'sd0, 16'sd12345
  };
  logic signed [15:0] edge_el [DIRECTED_LEN] = '{
    16'sd0, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767,
    16'sd6433, 16'sd6434, -16'sd6433, -16'sd6434, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd6434,
    -16'sd6434, 16'sd12868, -16'sd12868, 16'sd25736, -16'sd20000
  };

  spherical_to_cartesian #(
    .CORDIC_STAGES(ROT_STAGES),
    .OUT_FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    case (idle_mode)
      0: return 0;
      1: begin
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
      end
      default: begin
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 4);
        return $urandom_range(5, 40);
      end
    endcase
  endfunction

  task automatic send_angles(logic [15:0] az, logic [15:0] el);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {el, az};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_dirs.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_angles(in_tdata);
      if (out_tvalid && out_tready) board.check_direction(out_tdata);
    end
  end

  // receiver stalls
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall = pick_idle();
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("spherical_to_cartesian verification failed");
    $finish;
  end

  initial begin
    int          n, pick, k;
    logic [15:0] az, el;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_mode = 1;
    for (n = 0; n < DIRECTED_LEN; n++) send_angles(edge_az[n], edge_el[n]);
    drain_pipeline();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_mode = (n / 300) % 3;
      if (n == 900) drain_pipeline();
      pick = $urandom_range(0, 9);
      az = 16'($urandom());
      el = 16'($urandom());
      if (pick >= 5 && pick <= 6) begin
        // elevation right at the fold threshold
        k = FOLD_Q12 + $urandom_range(0, 8) - 4;
        el = pick[0] ? 16'(k) : 16'(-k);
      end else if (pick == 7) begin
        k = ($urandom_range(0, 1) ? 12868 : 25736) + $urandom_range(0, 16) - 8;
        az = $urandom_range(0, 1) ? 16'(k) : 16'(-k);
        el = 16'($urandom_range(0, 25736)) - 16'd12868;
      end else if (pick >= 8) begin
        az = 16'($urandom_range(0, 25736)) - 16'd12868;
        el = 16'($urandom_range(0, 25736)) - 16'd12868;
      end
      send_angles(az, el);
    end

    drain_pipeline();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (board.errors == 0 && board.pending_dirs.size() == 0)
      $display("spherical_to_cartesian verification clean");
    else
      $display("spherical_to_cartesian verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/s2c_pkg.sv
sv/s2c_bam.sv
sv/s2c_cordic_stage.sv
sv/s2c_product.sv
sv/spherical_to_cartesian.sv
tb/testbench.sv
